>>> design/first_fit_block_allocator_unit_assert.svh
// Assertion macros used by the allocator checker file.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Checked only outside reset.
`define FFBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

  localparam int HOLE_W  = 3;
  localparam int BYTE_W  = 16;
  localparam int TOTAL_W = 19;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  typedef struct packed {
    logic              granted;
    logic [HOLE_W-1:0] chosen_hole;
  } ffba_res_t;

endpackage

>>> design/ffba_if.sv
// Valid/ready channel interfaces for allocator requests and results.
interface ffba_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [ffba_pkg::HOLE_W-1:0]    hole_index;
  logic [ffba_pkg::BYTE_W-1:0]    byte_count;

  modport source (output valid, output mode, output hole_index, output byte_count,
                  input ready);
  modport sink   (input valid, input mode, input hole_index, input byte_count,
                  output ready);
endinterface

interface ffba_out_if;
  logic                           valid;
  logic                           ready;
  logic                           granted;
  logic [ffba_pkg::HOLE_W-1:0]    chosen_hole;
  logic [ffba_pkg::TOTAL_W-1:0]   free_total;

  modport source (output valid, output granted, output chosen_hole, output free_total,
                  input ready);
  modport sink   (input valid, input granted, input chosen_hole, input free_total,
                  output ready);
endinterface

>>> design/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/ffba_engine.sv
// Sequencer: loads hole sizes and scans holes one per cycle for a first fit.
module ffba_engine #(
  parameter int NUM_BLOCKS = 8,
  parameter int SIZE_BITS  = 16,
  parameter int TW         = SIZE_BITS + $clog2(NUM_BLOCKS + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic                           req_mode,
  input  logic [ffba_pkg::HOLE_W-1:0]    req_hole,
  input  logic [ffba_pkg::BYTE_W-1:0]    req_bytes,
  output logic                           res_valid,
  input  logic                           res_ready,
  output ffba_pkg::ffba_res_t            res,
  output logic [TW-1:0]                  res_total
);

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = (SIZE_BITS > ffba_pkg::BYTE_W) ? SIZE_BITS : ffba_pkg::BYTE_W;
  localparam logic [AW-1:0] LAST = AW'(NUM_BLOCKS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LSUB = 3'd1;
  localparam logic [2:0] ST_LADD = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [NUM_BLOCKS-1:0]          valid_r, valid_nxt;
  logic [TW-1:0]                  total_r, total_nxt;
  logic [AW-1:0]                  ptr_r, ptr_nxt;
  logic [ffba_pkg::BYTE_W-1:0]    bytes_r, bytes_nxt;
  logic [ffba_pkg::HOLE_W-1:0]    hole_r, hole_nxt;
  logic                           granted_r, granted_nxt;

  logic                           we, re;
  logic [AW-1:0]                  waddr, raddr;
  logic [SIZE_BITS-1:0]           wdata, rdata, cur;
  logic [CW-1:0]                  cur_ext, req_ext, diff;
  logic [31:0]                    ptr_ext;
  logic                           in_range;

  ffba_ram #(.WIDTH(SIZE_BITS), .DEPTH(NUM_BLOCKS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Unwritten holes read as zero.
  assign cur      = valid_r[ptr_r] ? rdata : '0;
  assign cur_ext  = CW'(cur);
  assign req_ext  = CW'(bytes_r);
  assign diff     = cur_ext - req_ext;
  assign ptr_ext  = 32'(ptr_r);
  assign in_range = 32'(req_hole) < NUM_BLOCKS;

  assign req_ready         = (state_r == ST_IDLE);
  assign res_valid         = (state_r == ST_DONE);
  assign res.granted       = granted_r;
  assign res.chosen_hole   = hole_r;
  assign res_total         = total_r;

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    total_nxt   = total_r;
    ptr_nxt     = ptr_r;
    bytes_nxt   = bytes_r;
    hole_nxt    = hole_r;
    granted_nxt = granted_r;
    we          = 1'b0;
    waddr       = ptr_r;
    wdata       = SIZE_BITS'(bytes_r);
    re          = 1'b0;
    raddr       = ptr_r;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          bytes_nxt   = req_bytes;
          granted_nxt = 1'b0;
          if (req_mode == ffba_pkg::MODE_LOAD) begin
            hole_nxt = req_hole;
            ptr_nxt  = AW'(req_hole);
            re       = in_range;
            raddr    = AW'(req_hole);
            state_nxt = in_range ? ST_LSUB : ST_DONE;
          end else begin
            hole_nxt  = '0;
            ptr_nxt   = '0;
            re        = 1'b1;
            raddr     = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LSUB: begin
        total_nxt        = total_r - TW'(cur);
        we               = 1'b1;
        valid_nxt[ptr_r] = 1'b1;
        state_nxt        = ST_LADD;
      end
      ST_LADD: begin
        total_nxt = total_r + TW'(SIZE_BITS'(bytes_r));
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        if (cur_ext >= req_ext) begin
          we               = 1'b1;
          wdata            = SIZE_BITS'(diff);
          valid_nxt[ptr_r] = 1'b1;
          total_nxt        = total_r - TW'(bytes_r);
          granted_nxt      = 1'b1;
          hole_nxt         = ptr_ext[ffba_pkg::HOLE_W-1:0];
          state_nxt        = ST_DONE;
        end else if (ptr_r == LAST) begin
          state_nxt = ST_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          re      = 1'b1;
          raddr   = ptr_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      total_r <= total_nxt;
    end
    ptr_r     <= ptr_nxt;
    bytes_r   <= bytes_nxt;
    hole_r    <= hole_nxt;
    granted_r <= granted_nxt;
  end

endmodule

>>> design/first_fit_block_allocator_unit.sv
// First-fit block allocator: top level with result register.
//
// in_ch carries one request per transfer: mode 0 loads byte_count as the free
// size of hole hole_index (ignored beyond the last hole), mode 1 allocates
// byte_count bytes from the lowest-numbered hole that can hold them.
// out_ch returns one result per request: granted, chosen_hole, and the total
// free bytes across all holes, saturated at 19 bits.
// A load passes through states LSUB and LADD to DONE (straight to DONE when the
// hole is out of range) and then to the output register. An allocation reads
// one hole per cycle from the hole-size RAM until a hole fits or the last is read.
// One request is processed at a time; in_ch.ready is high only when idle.
// A finished result waits in the output register, so the next request is
// taken while the receiver stalls; the following result then waits for it.
// Reset clears all hole sizes to zero (per-hole valid bits) and drops
// any pending result; the block is ready in the first cycle after reset.
module first_fit_block_allocator_unit #(
  parameter int NUM_BLOCKS = 8,
  parameter int SIZE_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  ffba_in_if.sink       in_ch,
  ffba_out_if.source    out_ch
);

  localparam int TW = SIZE_BITS + $clog2(NUM_BLOCKS + 1);

  logic                               res_valid, res_ready;
  ffba_pkg::ffba_res_t                res;
  logic [TW-1:0]                      res_total;
  logic [ffba_pkg::TOTAL_W-1:0]       total_sat;

  logic                               out_valid_r, out_valid_nxt;
  ffba_pkg::ffba_res_t                out_res_r, out_res_nxt;
  logic [ffba_pkg::TOTAL_W-1:0]       out_total_r, out_total_nxt;

  ffba_engine #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .TW         (TW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req_mode  (in_ch.mode),
    .req_hole  (in_ch.hole_index),
    .req_bytes (in_ch.byte_count),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .res_total (res_total)
  );

  assign total_sat = ((TW + 1)'(res_total) > (TW + 1)'(ffba_pkg::TOTAL_MAX))
                     ? ffba_pkg::TOTAL_MAX : ffba_pkg::TOTAL_W'(res_total);

  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_total_nxt = out_total_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
      out_total_nxt = total_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_res_r   <= out_res_nxt;
    out_total_r <= out_total_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.granted     = out_res_r.granted;
  assign out_ch.chosen_hole = out_res_r.chosen_hole;
  assign out_ch.free_total  = out_total_r;

endmodule

>>> design/ffba_checker.sv
// Port-level checker for the first-fit block allocator, bound to the top level.
`include "first_fit_block_allocator_unit_assert.svh"

module ffba_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_granted,
  input logic [ffba_pkg::HOLE_W-1:0]   out_chosen_hole,
  input logic [ffba_pkg::TOTAL_W-1:0]  out_free_total
);

  `FFBA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_granted) && $stable(out_chosen_hole) && $stable(out_free_total), "result changed while stalled")
  `FFBA_ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid, "result pending after reset")
  `FFBA_ASSERT(a_busy, clk, rst_n, in_valid && in_ready |=> !in_ready, "request taken while busy")
  `FFBA_ASSERT(a_res_src, clk, rst_n, $rose(out_valid) |-> $past(!in_ready), "result without a request in flight")

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_granted     (out_ch.granted),
  .out_chosen_hole (out_ch.chosen_hole),
  .out_free_total  (out_ch.free_total)
);

>>> sim/first_fit_block_allocator_unit_test.sv
// Self-checking testbench for the first-fit block allocator: directed table, then random requests.
`timescale 1ns / 100ps

module first_fit_block_allocator_unit_test;

  localparam int HOLE_W  = ffba_pkg::HOLE_W;
  localparam int BYTE_W  = ffba_pkg::BYTE_W;
  localparam int TOTAL_W = ffba_pkg::TOTAL_W;

  localparam int NUM_HOLES      = 8;
  localparam int N_DIRECTED     = 24;
  localparam int N_RANDOM       = 1950;
  localparam int DRAIN_AT       = 700;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic               granted;
    logic [HOLE_W-1:0]  chosen_hole;
    logic [TOTAL_W-1:0] free_total;
  } alloc_result_t;

  typedef struct packed {
    logic              mode;
    logic [HOLE_W-1:0] hole;
    logic [BYTE_W-1:0] bytes;
    logic              known;
    alloc_result_t     want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ffba_in_if  in_ch ();
  ffba_out_if out_ch ();

  first_fit_block_allocator_unit #(
    .NUM_BLOCKS (NUM_HOLES),
    .SIZE_BITS  (BYTE_W)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [BYTE_W-1:0] hole_free_model [NUM_HOLES];
  alloc_result_t     pending_results [$];
  int                error_count = 0;
  int                idle_cycles = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ffba_pkg::MODE_ALLOC, 3'd0, 16'h0000, 1'b1, '{1'b1, 3'd0, 19'd0}},
    '{ffba_pkg::MODE_ALLOC, 3'd5, 16'h0001, 1'b1, '{1'b0, 3'd0, 19'd0}},
    '{ffba_pkg::MODE_ALLOC, 3'd7, 16'hFFFF, 1'b1, '{1'b0, 3'd0, 19'd0}},
    '{ffba_pkg::MODE_LOAD,  3'd0, 16'hFFFF, 1'b1, '{1'b0, 3'd0, 19'd65535}},
    '{ffba_pkg::MODE_LOAD,  3'd1, 16'hFFFF, 1'b1, '{1'b0, 3'd1, 19'd131070}},
    '{ffba_pkg::MODE_LOAD,  3'd2, 16'hFFFF, 1'b1, '{1'b0, 3'd2, 19'd196605}},
    '{ffba_pkg::MODE_LOAD,  3'd3, 16'hFFFF, 1'b1, '{1'b0, 3'd3, 19'd262140}},
    '{ffba_pkg::MODE_LOAD,  3'd4, 16'hFFFF, 1'b1, '{1'b0, 3'd4, 19'd327675}},
    '{ffba_pkg::MODE_LOAD,  3'd5, 16'hFFFF, 1'b1, '{1'b0, 3'd5, 19'd393210}},
    '{ffba_pkg::MODE_LOAD,  3'd6, 16'hFFFF, 1'b1, '{1'b0, 3'd6, 19'd458745}},
    '{ffba_pkg::MODE_LOAD,  3'd7, 16'hFFFF, 1'b1, '{1'b0, 3'd7, 19'd524280}},
    '{ffba_pkg::MODE_ALLOC, 3'd0, 16'hFFFF, 1'b1, '{1'b1, 3'd0, 19'd458745}},
    '{ffba_pkg::MODE_ALLOC, 3'd7, 16'hFFFF, 1'b1, '{1'b1, 3'd1, 19'd393210}},
    '{ffba_pkg::MODE_ALLOC, 3'd2, 16'h0000, 1'b1, '{1'b1, 3'd0, 19'd393210}},
    '{ffba_pkg::MODE_LOAD,  3'd7, 16'h0000, 1'b1, '{1'b0, 3'd7, 19'd327675}},
    '{ffba_pkg::MODE_LOAD,  3'd2, 16'h0001, 1'b1, '{1'b0, 3'd2, 19'd262141}},
    '{ffba_pkg::MODE_ALLOC, 3'd0, 16'h0002, 1'b0, '0},
    '{ffba_pkg::MODE_ALLOC, 3'd0, 16'h0001, 1'b0, '0},
    '{ffba_pkg::MODE_LOAD,  3'd5, 16'hAAAA, 1'b0, '0},
    '{ffba_pkg::MODE_LOAD,  3'd6, 16'h5555, 1'b0, '0},
    '{ffba_pkg::MODE_ALLOC, 3'd3, 16'h5556, 1'b0, '0},
    '{ffba_pkg::MODE_ALLOC, 3'd4, 16'hFFFF, 1'b0, '0},
    '{ffba_pkg::MODE_LOAD,  3'd0, 16'h8000, 1'b0, '0},
    '{ffba_pkg::MODE_ALLOC, 3'd1, 16'h8001, 1'b0, '0}
  };

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the hole table and returns the result it produces.
  function automatic alloc_result_t apply_request(input logic m, input logic [HOLE_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    alloc_result_t r;
    int unsigned   sum;
    r = '0;
    if (m == ffba_pkg::MODE_LOAD) begin
      if (h < NUM_HOLES) hole_free_model[h] = b;
      r.chosen_hole = h;
    end else begin
      for (int k = 0; k < NUM_HOLES; k++) begin
        if (!r.granted && hole_free_model[k] >= b) begin
          hole_free_model[k] = hole_free_model[k] - b;
          r.granted          = 1'b1;
          r.chosen_hole      = k[HOLE_W-1:0];
        end
      end
    end
    sum = 0;
    foreach (hole_free_model[k]) sum += hole_free_model[k];
    r.free_total = (sum > ffba_pkg::TOTAL_MAX) ? ffba_pkg::TOTAL_MAX : sum[TOTAL_W-1:0];
    return r;
  endfunction

  function automatic int sender_gap(input int n);
    return ((n / 64) % 4 == 3) ? 0 : int'($urandom_range(0, 10));
  endfunction

  task automatic send_request(input logic m, input logic [HOLE_W-1:0] h,
                              input logic [BYTE_W-1:0] b, input int gap, input logic drain,
                              input logic known, input alloc_result_t want);
    alloc_result_t predicted;
    if (gap > 0 || drain) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        do @(posedge clk); while (pending_results.size() != 0);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.hole_index <= h;
    in_ch.byte_count <= b;
    do @(posedge clk); while (!in_ch.ready);
    predicted = apply_request(m, h, b);
    pending_results.push_back(known ? want : predicted);
  endtask

  initial begin : request_source
    logic              m;
    logic [HOLE_W-1:0] h;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] fill;
    foreach (hole_free_model[k]) hole_free_model[k] = '0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= ffba_pkg::MODE_LOAD;
    in_ch.hole_index <= '0;
    in_ch.byte_count <= '0;
    out_ch.ready     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_request(directed_rows[i].mode, directed_rows[i].hole, directed_rows[i].bytes,
                   sender_gap(i), 1'b0, directed_rows[i].known, directed_rows[i].want);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      h    = HOLE_W'($urandom_range(0, NUM_HOLES - 1));
      fill = hole_free_model[HOLE_W'($urandom_range(0, NUM_HOLES - 1))];
      if ($urandom_range(0, 99) < 30) begin
        m = ffba_pkg::MODE_LOAD;
        case ($urandom_range(0, 3))
          0: b = BYTE_W'($urandom);
          1: b = BYTE_W'($urandom_range(0, 255));
          2: b = $urandom_range(0, 1) ? '1 : '0;
          default: b = BYTE_W'($urandom_range(256, 4095));
        endcase
      end else begin
        m = ffba_pkg::MODE_ALLOC;
        // exact fits, one-over misses, partial takes of a live hole and random sizes
        case ($urandom_range(0, 4))
          0: b = fill;
          1: b = fill + 1'b1;
          2: b = fill >> 1;
          3: b = BYTE_W'($urandom_range(0, 255));
          default: b = BYTE_W'($urandom);
        endcase
      end
      send_request(m, h, b, sender_gap(N_DIRECTED + i), i == DRAIN_AT, 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_sink
    int            stall;
    int            n_results;
    alloc_result_t want;
    n_results = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = ((n_results / 50) % 4 == 1) ? 0 : int'($urandom_range(0, 10));
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      n_results++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: granted %0d chosen_hole %0d free_total %0d",
               out_ch.granted, out_ch.chosen_hole, out_ch.free_total);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, out_ch.granted);
          error_count++;
        end
        if (out_ch.chosen_hole !== want.chosen_hole) begin
          $error("chosen_hole: expected %0d, got %0d", want.chosen_hole, out_ch.chosen_hole);
          error_count++;
        end
        if (out_ch.free_total !== want.free_total) begin
          $error("free_total: expected %0d, got %0d", want.free_total, out_ch.free_total);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

>>> filelist.f
+incdir+design
design/ffba_pkg.sv
design/ffba_if.sv
design/ffba_ram.sv
design/ffba_engine.sv
design/first_fit_block_allocator_unit.sv
design/ffba_checker.sv
sim/first_fit_block_allocator_unit_test.sv
